### hw/rtl/ugt_pkg.sv
package ugt_pkg;

	localparam int MAX_KEY_BYTES = 4;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [1:0] {
		OP_TEXT  = 2'd0,
		OP_MAP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_TEXT     = 3'd0,
		ST_ADDED    = 3'd1,
		ST_REPLACED = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		K_TEXT,
		K_MAP,
		K_EMPTY,
		K_CLEAR
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DECIDE,
		BK_UPDATE,
		BK_EMIT,
		BK_TABLE
	} bk_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        eot;
		logic [31:0] key;
		logic [2:0]  klen;
		logic [31:0] code;
		logic [2:0]  clen;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	function automatic logic [31:0] low_bytes(input logic [31:0] v, input logic [2:0] n);
		logic [31:0] r;
		case (n)
			3'd0: r = 32'h0;
			3'd1: r = {24'h0, v[7:0]};
			3'd2: r = {16'h0, v[15:0]};
			3'd3: r = {8'h0, v[23:0]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/ugt_ram.sv
module ugt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/ugt_front.sv
module ugt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [79:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               s_tlast,
	output ugt_pkg::queue_out_t q_out,
	input  logic               q_pop
);

	ugt_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	ugt_pkg::item_t in_item;
	logic           push;
	logic           pop;

	always_comb begin
		in_item.data_byte = s_tdata[7:0];
		in_item.eot       = s_tlast;
		in_item.key       = s_tdata[39:8];
		in_item.klen      = s_tdata[42:40];
		in_item.code      = s_tdata[74:43];
		in_item.clen      = s_tdata[77:75];
		case (ugt_pkg::opcode_t'(s_tuser))
			ugt_pkg::OP_TEXT:  in_item.kind = ugt_pkg::K_TEXT;
			ugt_pkg::OP_MAP:   in_item.kind = (s_tdata[42:40] == 3'd0 || s_tdata[77:75] == 3'd0) ?
			                                  ugt_pkg::K_EMPTY : ugt_pkg::K_MAP;
			ugt_pkg::OP_CLEAR: in_item.kind = ugt_pkg::K_CLEAR;
			default:           in_item.kind = ugt_pkg::K_TEXT;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	// drop unknown opcodes at the door
	assign push = s_tvalid && s_tready && (ugt_pkg::opcode_t'(s_tuser) != ugt_pkg::OP_NONE);
	assign pop  = q_pop && (cnt_q != 2'd0);

	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/ugt_back.sv
module ugt_back #(
	parameter int TABLE_ENTRIES  = 128,
	parameter int MAX_CODE_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ugt_pkg::queue_out_t q_out,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic [3:0]          m_tuser,
	output logic                m_tlast
);

	localparam int CODE_BYTES = (MAX_CODE_BYTES < 4) ? MAX_CODE_BYTES : 4;
	localparam int CODE_W     = 8 * CODE_BYTES;
	localparam int AW         = $clog2(TABLE_ENTRIES);
	localparam int UW         = $clog2(TABLE_ENTRIES + 1);
	localparam int RAM_W      = 32 + 3 + CODE_W + 3;

	ugt_pkg::bk_state_t state_q, state_d;
	ugt_pkg::item_t     cur_q;
	ugt_pkg::status_t   status_q;

	logic [31:0]     win_q;
	logic [2:0]      fill_q;
	logic [UW-1:0]   used_q;
	logic [UW-1:0]   scan_q;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic [2:0]      best_len_q;
	logic [CODE_W-1:0] best_code_q;
	logic [2:0]      best_clen_q;
	logic            hit_q;
	logic [AW-1:0]   hit_idx_q;
	logic [31:0]     emit_buf_q;
	logic [2:0]      emit_cnt_q;
	logic            emit_last_q;

	logic            m_tvalid_q;
	logic [7:0]      m_tdata_q;
	logic [3:0]      m_tuser_q;
	logic            m_tlast_q;

	// ram side
	logic              rd_en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [RAM_W-1:0]  wr_data;
	logic [RAM_W-1:0]  rd_data;
	logic [31:0]       r_key;
	logic [2:0]        r_klen;
	logic [CODE_W-1:0] r_code;
	logic [2:0]        r_clen;

	logic        slot_free;
	logic        scan_more;
	logic        scan_done;
	logic        match_dec;
	logic        match_map;
	logic        table_full;
	logic [2:0]  sat_clen;
	logic [31:0] masked_code;
	logic [2:0]  append_fill;
	logic        text_decide;

	// decision results
	logic [31:0] dec_buf;
	logic [2:0]  dec_cnt;
	logic [2:0]  dec_consume;
	logic [31:0] dec_win;
	logic [2:0]  dec_fill;
	logic [2:0]  skip;
	logic [31:0] best_code_ext;

	assign slot_free  = !m_tvalid_q || m_tready;
	assign scan_more  = (scan_q < used_q);
	assign scan_done  = !scan_more && !rd_vld_s1;
	assign table_full = (used_q >= UW'(TABLE_ENTRIES));

	assign {r_key, r_klen, r_code, r_clen} = rd_data;

	assign match_dec = rd_vld_s1 && (r_klen != 3'd0) && (r_klen <= fill_q) &&
	                   (r_klen <= 3'(ugt_pkg::MAX_KEY_BYTES)) && (r_klen > best_len_q) &&
	                   (ugt_pkg::low_bytes(r_key, r_klen) == ugt_pkg::low_bytes(win_q, r_klen));
	assign match_map = rd_vld_s1 && (r_klen == cur_q.klen) &&
	                   (ugt_pkg::low_bytes(r_key, cur_q.klen) ==
	                    ugt_pkg::low_bytes(cur_q.key, cur_q.klen));

	assign sat_clen    = (cur_q.clen > 3'(CODE_BYTES)) ? 3'(CODE_BYTES) : cur_q.clen;
	assign masked_code = ugt_pkg::low_bytes(cur_q.code, sat_clen);

	assign append_fill = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
	assign text_decide = (append_fill == 3'd4) || q_out.item.eot;

	always_comb begin
		best_code_ext = 32'h0;
		best_code_ext[CODE_W-1:0] = best_code_q;
		skip = 3'd1;
		if ((win_q[7:0] & ugt_pkg::LEAD2_MASK) == ugt_pkg::LEAD2_VAL) begin
			skip = 3'd2;
		end else if ((win_q[7:0] & ugt_pkg::LEAD3_MASK) == ugt_pkg::LEAD3_VAL) begin
			skip = 3'd3;
		end else if ((win_q[7:0] & ugt_pkg::LEAD4_MASK) == ugt_pkg::LEAD4_VAL) begin
			skip = 3'd4;
		end
		if (skip > fill_q) begin
			skip = fill_q;
		end
		if (best_len_q != 3'd0) begin
			dec_buf     = best_code_ext;
			dec_cnt     = best_clen_q;
			dec_consume = best_len_q;
		end else if (win_q[7:0] <= ugt_pkg::ASCII_MAX) begin
			dec_buf     = {24'h0, win_q[7:0]};
			dec_cnt     = 3'd1;
			dec_consume = 3'd1;
		end else begin
			dec_buf     = {24'h0, ugt_pkg::SPACE_CHAR};
			dec_cnt     = 3'd1;
			dec_consume = skip;
		end
		case (dec_consume)
			3'd0:    dec_win = win_q;
			3'd1:    dec_win = {8'h0, win_q[31:8]};
			3'd2:    dec_win = {16'h0, win_q[31:16]};
			3'd3:    dec_win = {24'h0, win_q[31:24]};
			default: dec_win = 32'h0;
		endcase
		dec_fill = (dec_consume >= fill_q) ? 3'd0 : fill_q - dec_consume;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ugt_pkg::BK_IDLE: begin
				if (q_out.valid) begin
					case (q_out.item.kind)
						ugt_pkg::K_TEXT:  state_d = text_decide ? ugt_pkg::BK_SCAN : ugt_pkg::BK_IDLE;
						ugt_pkg::K_MAP:   state_d = ugt_pkg::BK_SCAN;
						default:          state_d = ugt_pkg::BK_TABLE;
					endcase
				end
			end
			ugt_pkg::BK_SCAN: begin
				if (scan_done) begin
					state_d = (cur_q.kind == ugt_pkg::K_MAP) ? ugt_pkg::BK_UPDATE : ugt_pkg::BK_DECIDE;
				end
			end
			ugt_pkg::BK_DECIDE: state_d = ugt_pkg::BK_EMIT;
			ugt_pkg::BK_UPDATE: state_d = ugt_pkg::BK_TABLE;
			ugt_pkg::BK_EMIT: begin
				if (slot_free && emit_cnt_q == 3'd1) begin
					state_d = emit_last_q ? ugt_pkg::BK_IDLE : ugt_pkg::BK_SCAN;
				end
			end
			ugt_pkg::BK_TABLE: begin
				if (slot_free) begin
					state_d = ugt_pkg::BK_IDLE;
				end
			end
			default: state_d = ugt_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = {ugt_pkg::low_bytes(cur_q.key, cur_q.klen), cur_q.klen,
		           masked_code[CODE_W-1:0], sat_clen};
		case (state_q)
			ugt_pkg::BK_IDLE: q_pop = q_out.valid;
			ugt_pkg::BK_SCAN: rd_en = scan_more;
			ugt_pkg::BK_UPDATE: begin
				if (hit_q) begin
					wr_en = 1'b1;
				end else if (!table_full) begin
					wr_en   = 1'b1;
					wr_addr = used_q[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	ugt_ram #(
		.WIDTH(RAM_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(scan_q[AW-1:0]),
		.rdata(rd_data)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ugt_pkg::BK_IDLE && q_out.valid) begin
			cur_q <= q_out.item;
		end
		if (rd_vld_s1 && match_dec) begin
			best_code_q <= r_code;
			best_clen_q <= r_clen;
		end
		if (rd_vld_s1 && match_map) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_q[AW-1:0];
		end
		if (state_q == ugt_pkg::BK_DECIDE) begin
			emit_buf_q  <= dec_buf;
			emit_last_q <= !(cur_q.eot && dec_fill != 3'd0);
		end else if (state_q == ugt_pkg::BK_EMIT && slot_free) begin
			emit_buf_q <= {8'h0, emit_buf_q[31:8]};
		end
		if (state_q == ugt_pkg::BK_UPDATE) begin
			if (hit_q) begin
				status_q <= ugt_pkg::ST_REPLACED;
			end else if (table_full) begin
				status_q <= ugt_pkg::ST_FULL;
			end else begin
				status_q <= ugt_pkg::ST_ADDED;
			end
		end else if (state_q == ugt_pkg::BK_IDLE && q_out.valid) begin
			status_q <= (q_out.item.kind == ugt_pkg::K_CLEAR) ? ugt_pkg::ST_CLEARED :
			            ugt_pkg::ST_EMPTY;
		end
		if (slot_free) begin
			if (state_q == ugt_pkg::BK_EMIT) begin
				m_tdata_q <= emit_buf_q[7:0];
				m_tlast_q <= emit_last_q && emit_cnt_q == 3'd1;
				m_tuser_q <= {ugt_pkg::ST_TEXT, emit_last_q && emit_cnt_q == 3'd1 && cur_q.eot};
			end else if (state_q == ugt_pkg::BK_TABLE) begin
				m_tdata_q <= 8'h00;
				m_tlast_q <= 1'b1;
				m_tuser_q <= {status_q, 1'b0};
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ugt_pkg::BK_IDLE;
			win_q      <= 32'h0;
			fill_q     <= 3'd0;
			used_q     <= '0;
			scan_q     <= '0;
			rd_vld_s1  <= 1'b0;
			best_len_q <= 3'd0;
			hit_q      <= 1'b0;
			emit_cnt_q <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				scan_q <= scan_q + UW'(1);
			end
			if (rd_vld_s1 && match_map) begin
				hit_q <= 1'b1;
			end
			if (rd_vld_s1 && match_dec) begin
				best_len_q <= r_klen;
			end
			case (state_q)
				ugt_pkg::BK_IDLE: begin
					scan_q     <= '0;
					best_len_q <= 3'd0;
					hit_q      <= 1'b0;
					if (q_out.valid) begin
						if (q_out.item.kind == ugt_pkg::K_TEXT && fill_q < 3'd4) begin
							case (fill_q[1:0])
								2'd0: win_q[7:0]   <= q_out.item.data_byte;
								2'd1: win_q[15:8]  <= q_out.item.data_byte;
								2'd2: win_q[23:16] <= q_out.item.data_byte;
								default: win_q[31:24] <= q_out.item.data_byte;
							endcase
							fill_q <= append_fill;
						end
						if (q_out.item.kind == ugt_pkg::K_CLEAR) begin
							used_q <= '0;
						end
					end
				end
				ugt_pkg::BK_DECIDE: begin
					win_q      <= dec_win;
					fill_q     <= dec_fill;
					emit_cnt_q <= dec_cnt;
				end
				ugt_pkg::BK_UPDATE: begin
					if (!hit_q && !table_full) begin
						used_q <= used_q + UW'(1);
					end
				end
				ugt_pkg::BK_EMIT: begin
					if (slot_free) begin
						emit_cnt_q <= emit_cnt_q - 3'd1;
						// rearm the scan for the next window position
						scan_q     <= '0;
						best_len_q <= 3'd0;
					end
				end
				default: ;
			endcase
			if (slot_free && (state_q == ugt_pkg::BK_EMIT || state_q == ugt_pkg::BK_TABLE)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

### hw/rtl/utf8_glyph_code_transcoder_core.sv
// Channel   Dir  tdata (low bit up)                                   tuser             tlast
// s_*       in   data_byte, key_bytes, key_length, code_bytes,         opcode            end_of_text
//                code_length, zero pad to 80 bits
// m_*       out  out_byte                                             last_of_text,     last_of_run
//                                                                     status
//
// A text byte that neither fills the window nor ends the text is only appended
// to it. Each decision scans the table once, one entry a cycle through the RAM
// read port, and then emits its bytes. A mapping write also scans the table
// before its update. A two-entry input queue lets the source run ahead of the
// scan; the output register holds a byte while m_tready is low and the engine
// waits. Reset clears the window and the fill count at once; no clearing pass
// runs.
module utf8_glyph_code_transcoder_core #(
	parameter int TABLE_ENTRIES  = 128,
	parameter int MAX_CODE_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // data_byte, key_bytes, key_length, code_bytes, code_length
	input  logic [1:0]  s_tuser,  // opcode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte
	output logic [3:0]  m_tuser,  // last_of_text, status
	output logic        m_tlast
);

	ugt_pkg::queue_out_t q_out;
	logic                q_pop;

	ugt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.q_out   (q_out),
		.q_pop   (q_pop)
	);

	ugt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_BYTES(MAX_CODE_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_out   (q_out),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

### hw/rtl/ugt_checker.sv
module ugt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// stalled output transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_text_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tuser[3:1] == 3'd0)
		else $error("end of text without end of run");

	a_table: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:1] != 3'd0 |-> m_tdata == 8'h00 && m_tlast)
		else $error("table result malformed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[3:1] != 3'd6 && m_tuser[3:1] != 3'd7)
		else $error("undefined status");

endmodule

bind utf8_glyph_code_transcoder_core ugt_checker u_chk (.*);

### verif/utf8_glyph_code_transcoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_glyph_code_transcoder_core_tb;

	localparam int TABLE_SIZE = 128;
	localparam int CODE_MAX   = 4;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int PHASE_SEND [4] = '{0, 63, 0, 17};
	localparam int PHASE_RECV [4] = '{0, 0, 63, 17};

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_byte;
		logic        eot;
		logic [31:0] key;
		logic [2:0]  klen;
		logic [31:0] code;
		logic [2:0]  clen;
	} text_cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       last_of_text;
		logic [2:0] status;
	} glyph_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	utf8_glyph_code_transcoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// predictor state
	logic [31:0] map_key [TABLE_SIZE];
	logic [2:0]  map_klen [TABLE_SIZE];
	logic [31:0] map_code [TABLE_SIZE];
	logic [2:0]  map_clen [TABLE_SIZE];
	logic        map_valid [TABLE_SIZE];
	int          map_used;
	logic [31:0] win_bytes;
	int          win_fill;

	text_cmd_t  pending_cmds[$];
	glyph_out_t expected_glyphs[$];
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_send;
	int         mismatches = 0;
	longint     cycle_count;

	function automatic logic [31:0] keep_bytes(logic [31:0] v, int n);
		if (n >= 4) return v;
		return v & ((32'h1 << (8 * n)) - 32'h1);
	endfunction

	function automatic int lookup_key(logic [31:0] k, int n);
		for (int i = 0; i < TABLE_SIZE; i++)
			if (map_valid[i] && map_klen[i] == n &&
				keep_bytes(map_key[i], n) == keep_bytes(k, n))
				return i;
		return -1;
	endfunction

	function automatic void push_glyph(logic [7:0] b, ref int cnt);
		glyph_out_t g;
		if (cnt >= 16) return;
		g = '{b, 1'b0, 1'b0, ugt_pkg::ST_TEXT};
		expected_glyphs.push_back(g);
		cnt++;
	endfunction

	function automatic void shift_window(int n);
		win_bytes = (n >= 4) ? 32'h0 : win_bytes >> (8 * n);
		win_fill  = (n >= win_fill) ? 0 : win_fill - n;
	endfunction

	function automatic void decide_head(ref int cnt);
		int idx;
		int skip;
		logic [7:0] c;
		for (int l = (win_fill < 4 ? win_fill : 4); l > 0; l--) begin
			idx = lookup_key(win_bytes, l);
			if (idx >= 0) begin
				for (int k = 0; k < map_clen[idx]; k++)
					push_glyph(map_code[idx][8*k +: 8], cnt);
				shift_window(l);
				return;
			end
		end
		c = win_bytes[7:0];
		if (c <= ugt_pkg::ASCII_MAX) begin
			push_glyph(c, cnt);
			shift_window(1);
			return;
		end
		skip = 1;
		if ((c & ugt_pkg::LEAD2_MASK) == ugt_pkg::LEAD2_VAL) skip = 2;
		else if ((c & ugt_pkg::LEAD3_MASK) == ugt_pkg::LEAD3_VAL) skip = 3;
		else if ((c & ugt_pkg::LEAD4_MASK) == ugt_pkg::LEAD4_VAL) skip = 4;
		if (skip > win_fill) skip = win_fill;
		push_glyph(ugt_pkg::SPACE_CHAR, cnt);
		shift_window(skip);
	endfunction

	function automatic void push_table(ugt_pkg::status_t st);
		glyph_out_t g;
		g = '{8'h00, 1'b1, 1'b0, st};
		expected_glyphs.push_back(g);
	endfunction

	function automatic void predict_transcode(text_cmd_t cmd);
		int cnt;
		int idx;
		int clen;
		ugt_pkg::status_t st;
		glyph_out_t g;
		cnt = 0;
		case (ugt_pkg::opcode_t'(cmd.opcode))
			ugt_pkg::OP_TEXT: begin
				if (win_fill < 4) begin
					win_bytes |= 32'(cmd.data_byte) << (8 * win_fill);
					win_fill++;
				end
				while (win_fill >= 4 || (cmd.eot && win_fill > 0))
					decide_head(cnt);
				if (cnt > 0) begin
					g = expected_glyphs.pop_back();
					g.last_of_run = 1'b1;
					g.last_of_text = cmd.eot;
					expected_glyphs.push_back(g);
				end
			end
			ugt_pkg::OP_MAP: begin
				if (cmd.klen == 0 || cmd.clen == 0) begin
					push_table(ugt_pkg::ST_EMPTY);
					return;
				end
				clen = cmd.clen > CODE_MAX ? CODE_MAX : cmd.clen;
				idx = lookup_key(cmd.key, cmd.klen);
				if (idx >= 0) begin
					st = ugt_pkg::ST_REPLACED;
				end else begin
					if (map_used >= TABLE_SIZE) begin
						push_table(ugt_pkg::ST_FULL);
						return;
					end
					idx = map_used;
					map_used++;
					st = ugt_pkg::ST_ADDED;
				end
				map_key[idx]   = keep_bytes(cmd.key, cmd.klen);
				map_klen[idx]  = cmd.klen;
				map_code[idx]  = keep_bytes(cmd.code, clen);
				map_clen[idx]  = 3'(clen);
				map_valid[idx] = 1'b1;
				push_table(st);
			end
			ugt_pkg::OP_CLEAR: begin
				for (int i = 0; i < TABLE_SIZE; i++) map_valid[i] = 1'b0;
				map_used = 0;
				push_table(ugt_pkg::ST_CLEARED);
			end
			default: ;
		endcase
	endfunction

	function automatic text_cmd_t noise_fields();
		text_cmd_t c;
		c.opcode    = 2'($urandom_range(0, 3));
		c.data_byte = 8'($urandom);
		c.eot       = 1'($urandom);
		c.key       = $urandom;
		c.klen      = 3'($urandom);
		c.code      = $urandom;
		c.clen      = 3'($urandom);
		return c;
	endfunction

	function automatic text_cmd_t make_text(logic [7:0] b, logic eot);
		text_cmd_t c;
		c = noise_fields();
		c.opcode = ugt_pkg::OP_TEXT;
		c.data_byte = b;
		c.eot = eot;
		return c;
	endfunction

	function automatic text_cmd_t make_map(logic [31:0] k, int kl, logic [31:0] cd, int cl);
		text_cmd_t c;
		c = noise_fields();
		c.opcode = ugt_pkg::OP_MAP;
		c.key = k;
		c.klen = 3'(kl);
		c.code = cd;
		c.clen = 3'(cl);
		return c;
	endfunction

	function automatic text_cmd_t make_op(ugt_pkg::opcode_t op);
		text_cmd_t c;
		c = noise_fields();
		c.opcode = op;
		return c;
	endfunction

	// UTF-8-ish byte biased toward lead bytes, continuations and ASCII
	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(8'h00, 8'h7F));
			1: return 8'($urandom_range(8'hC0, 8'hDF));
			2: return 8'($urandom_range(8'hE0, 8'hEF));
			3: return 8'($urandom_range(8'hF0, 8'hFF));
			4: return 8'($urandom_range(8'h80, 8'hBF));
			default: return 8'($urandom_range(8'h41, 8'h43));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		text_cmd_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_cmds.size() > 0 && !hold_send &&
				$urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_cmds.pop_front();
				predict_transcode(nxt);
				s_tvalid <= 1'b1;
				s_tdata  <= {2'b00, nxt.clen, nxt.code, nxt.klen, nxt.key, nxt.data_byte};
				s_tuser  <= nxt.opcode;
				s_tlast  <= nxt.eot;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		glyph_out_t got;
		glyph_out_t exp_g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[3:1]};
				if (expected_glyphs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: byte %02h last %0b eot %0b status %0d",
							got.out_byte, got.last_of_run, got.last_of_text, got.status);
				end else begin
					exp_g = expected_glyphs.pop_front();
					if (got !== exp_g) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp byte %02h last %0b eot %0b status %0d,",
								" got byte %02h last %0b eot %0b status %0d"},
								exp_g.out_byte, exp_g.last_of_run, exp_g.last_of_text,
								exp_g.status, got.out_byte, got.last_of_run,
								got.last_of_text, got.status);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || s_tvalid || expected_glyphs.size() > 0)
			@(posedge clk);
	endtask

	task automatic add_random_text(int n);
		int wlen;
		while (n > 0) begin
			wlen = $urandom_range(1, 8);
			for (int i = 0; i < wlen && n > 0; i++, n--)
				pending_cmds.push_back(make_text(pick_text_byte(),
					(i == wlen - 1 || n == 1) ? 1'($urandom_range(0, 3) != 0) : 1'b0));
		end
	endtask

	task automatic add_random_maps(int n);
		int kl;
		for (int i = 0; i < n; i++) begin
			kl = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4);
			pending_cmds.push_back(make_map(
				{8'($urandom), 8'($urandom), pick_text_byte(), pick_text_byte()}, kl,
				$urandom, $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) :
				$urandom_range(1, 4)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		hold_send = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < TABLE_SIZE; i++) map_valid[i] = 1'b0;
		map_used = 0;
		win_bytes = '0;
		win_fill = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: mappings of each length, empty, long key, replace, unknown op
		pending_cmds.push_back(make_map(32'h0000_0041, 1, 32'h0000_00AA, 1));
		pending_cmds.push_back(make_map(32'h0000_A9C3, 2, 32'h0000_BBCC, 2));
		pending_cmds.push_back(make_map(32'h00AC_82E2, 3, 32'hFFFF_FFFF, 7));
		pending_cmds.push_back(make_map(32'h9F98_80F0, 4, 32'h1122_3344, 3));
		pending_cmds.push_back(make_map(32'hFFFF_FF41, 1, 32'h0000_0055, 1));
		pending_cmds.push_back(make_map(32'h1234_5678, 0, 32'h1, 1));
		pending_cmds.push_back(make_map(32'h1234_5678, 2, 32'h1, 0));
		pending_cmds.push_back(make_map(32'hFFFF_FFFF, 7, 32'h0, 4));
		pending_cmds.push_back(make_op(ugt_pkg::OP_NONE));
		pending_cmds.push_back(make_text(8'h41, 1'b0));
		pending_cmds.push_back(make_text(8'hC3, 1'b0));
		pending_cmds.push_back(make_text(8'hA9, 1'b0));
		pending_cmds.push_back(make_text(8'h00, 1'b0));
		pending_cmds.push_back(make_text(8'hE2, 1'b0));
		pending_cmds.push_back(make_text(8'h82, 1'b0));
		pending_cmds.push_back(make_text(8'hAC, 1'b0));
		pending_cmds.push_back(make_text(8'hF0, 1'b0));
		pending_cmds.push_back(make_text(8'h9F, 1'b1));
		pending_cmds.push_back(make_text(8'hFF, 1'b0));
		pending_cmds.push_back(make_text(8'h80, 1'b0));
		pending_cmds.push_back(make_text(8'h7F, 1'b1));
		pending_cmds.push_back(make_text(8'hE0, 1'b1));
		pending_cmds.push_back(make_op(ugt_pkg::OP_CLEAR));
		pending_cmds.push_back(make_text(8'h41, 1'b1));
		wait_drained();

		// fill the table past its size to reach the full case
		for (int i = 0; i < TABLE_SIZE + 2; i++)
			pending_cmds.push_back(make_map(32'(i) << 8 | 32'h0001_0000, 3, $urandom, 1));
		pending_cmds.push_back(make_map(32'h0000_0041, 1, 32'h66, 1));
		pending_cmds.push_back(make_text(8'h41, 1'b1));
		pending_cmds.push_back(make_op(ugt_pkg::OP_CLEAR));
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = PHASE_SEND[p];
			recv_stall_pct = PHASE_RECV[p];
			add_random_maps(8);
			add_random_text(30);
			if ($urandom_range(0, 1)) pending_cmds.push_back(make_op(ugt_pkg::OP_CLEAR));
			pending_cmds.push_back(noise_fields());
			if (p == 1) begin
				// sender holds off until all results are back
				while (pending_cmds.size() > 0) @(posedge clk);
				hold_send = 1'b1;
				add_random_text(6);
				while (s_tvalid || expected_glyphs.size() > 0) @(posedge clk);
				hold_send = 1'b0;
			end
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pending_cmds.push_back(make_text(8'h20, 1'b1));
		wait_drained();
		repeat (TABLE_SIZE * 4 + 50) @(posedge clk);

		if (mismatches == 0 && expected_glyphs.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/ugt_pkg.sv
hw/rtl/ugt_ram.sv
hw/rtl/ugt_front.sv
hw/rtl/ugt_back.sv
hw/rtl/utf8_glyph_code_transcoder_core.sv
hw/rtl/ugt_checker.sv
verif/utf8_glyph_code_transcoder_core_tb.sv
